// ----- rtl/hsf_pkg.sv -----
// hsf_pkg: sizes, hash constant and memory request type for the seen filter
// no dependencies

package hsf_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned TABLE_SIZE  = 4096;   // power of two
   localparam int unsigned PROBE_LIMIT = 8;
   localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
   localparam int unsigned CNT_W       = $clog2(PROBE_LIMIT + 1);

   localparam logic [ADDR_W-1:0] HASH_MULT = 32'd2654435761;

   // one write and one read request to the slot memory per cycle
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [ADDR_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

endpackage

// ----- rtl/hsf_channels.sv -----
// hsf_channels: valid/ready channel interfaces for request and response items
// depends on hsf_pkg

interface hsf_req_if;
   import hsf_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface hsf_rsp_if;
   logic valid;
   logic ready;
   logic already_seen;
   logic replaced_entry;

   modport source (output valid, output already_seen, output replaced_entry, input ready);
   modport sink   (input valid, input already_seen, input replaced_entry, output ready);
endinterface

// ----- rtl/hsf_table.sv -----
// hsf_table: slot memory, one write port and one registered read port
// depends on hsf_pkg

module hsf_table (
   input  logic                       clock,
   input  hsf_pkg::mem_req_type       mem_req,
   output logic [hsf_pkg::ADDR_W-1:0] rd_data
);
   import hsf_pkg::*;

   logic [ADDR_W-1:0] slot_mem [TABLE_SIZE];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= slot_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hashed_seen_filter.sv -----
// hashed_seen_filter: top level, probe sequencer around the slot memory
// depends on hsf_pkg, hsf_channels, hsf_table

// Filter of recently seen 32-bit addresses, kept in a 4096-slot open-addressed
// hash table with linear probing. Each request item carries one address; each
// produces exactly one response item. The home slot is the low 12 bits of
// address * 2654435761. Up to 8 slots from home (wrapping) are read one per
// cycle through the memory's single read port: an equal entry reports
// already_seen, the first empty (zero) slot takes the address and reports new,
// and a window with neither overwrites the home slot and reports
// replaced_entry. A zero address reports already_seen and is never stored.
// After reset the block runs a clearing pass over all 4096 slots, one slot per
// cycle, with req_ch.ready low.
// Sequence: an item is hashed, then probed slot by slot until it resolves, the
// last read data passing through the read port's register, and its result is
// loaded before the next accept; a zero address goes straight to the result
// load. The probe reads go one at a time through the memory's single read port.
// The result sits in an output register, so a waiting response does not hold
// back the next request.

module hashed_seen_filter (
   input  logic     clock,
   input  logic     reset,
   hsf_req_if.sink   req_ch,
   hsf_rsp_if.source rsp_ch
);
   import hsf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  clr_idx_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [IDX_W-1:0]  home_ff;
   logic [CNT_W-1:0]  iss_ff;        // probe reads issued so far
   logic [IDX_W-1:0]  chk_slot_ff;   // slot of the data now at the read port
   logic              rd_vld_ff;     // read data valid this cycle
   logic              res_seen_ff;
   logic              res_repl_ff;
   logic              rsp_valid_ff;
   logic              rsp_seen_ff;
   logic              rsp_repl_ff;

   mem_req_type       mem_req;
   logic [ADDR_W-1:0] rd_data;
   logic [2*IDX_W-1:0] hash_prod;
   logic [IDX_W-1:0]  rd_slot;
   logic              issue;
   logic              hit;
   logic              empty;
   logic              last;
   logic              decide;
   logic              req_accept;

   hsf_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // low bits of the product only depend on low bits of the operands
   assign hash_prod = (2*IDX_W)'(addr_ff[IDX_W-1:0]) * (2*IDX_W)'(HASH_MULT[IDX_W-1:0]);

   // next probe slot, wraps at the table end
   assign rd_slot = home_ff + IDX_W'(iss_ff);
   assign issue   = (state_ff == ST_SCAN) && (iss_ff != CNT_W'(PROBE_LIMIT));

   // compare the entry that came back from the previous read
   assign hit    = rd_vld_ff && (rd_data == addr_ff);
   assign empty  = rd_vld_ff && (rd_data == '0);
   assign last   = rd_vld_ff && (iss_ff == CNT_W'(PROBE_LIMIT));
   assign decide = hit || empty || last;

   always_comb begin
      mem_req         = '0;
      mem_req.rd_en   = issue;
      mem_req.rd_addr = rd_slot;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_idx_ff;
            mem_req.wr_data = '0;
         end
         ST_SCAN: begin
            if (!hit && empty) begin
               // first empty slot takes the address
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = chk_slot_ff;
               mem_req.wr_data = addr_ff;
            end else if (!hit && last) begin
               // window full, home slot is overwritten
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = home_ff;
               mem_req.wr_data = addr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_accept = (state_ff == ST_IDLE) && req_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response register drains independently of the sequencer,
         // in the done state the reload below handles it
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == IDX_W'(TABLE_SIZE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  addr_ff <= req_ch.address;
                  if (req_ch.address == '0) begin
                     // zero marks empty slots, never stored
                     res_seen_ff <= 1'b1;
                     res_repl_ff <= 1'b0;
                     state_ff    <= ST_DONE;
                  end else begin
                     state_ff <= ST_HASH;
                  end
               end
            end
            ST_HASH: begin
               home_ff   <= hash_prod[IDX_W-1:0];
               iss_ff    <= '0;
               rd_vld_ff <= 1'b0;
               state_ff  <= ST_SCAN;
            end
            ST_SCAN: begin
               if (issue) begin
                  iss_ff      <= iss_ff + 1'b1;
                  chk_slot_ff <= rd_slot;
               end
               if (decide) begin
                  res_seen_ff <= hit;
                  res_repl_ff <= !hit && !empty;
                  rd_vld_ff   <= 1'b0;
                  state_ff    <= ST_DONE;
               end else begin
                  rd_vld_ff <= issue;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seen_ff  <= res_seen_ff;
                  rsp_repl_ff  <= res_repl_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.already_seen   = rsp_seen_ff;
   assign rsp_ch.replaced_entry = rsp_repl_ff;

endmodule

// ----- rtl/hsf_checker.sv -----
// hsf_checker: port-level assertions for the seen filter, bound to the top level
// depends on hashed_seen_filter

module hsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_already_seen,
   input logic rsp_replaced_entry
);

   // clearing pass starts right after reset, no item taken
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // one item at a time: busy after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready in the cycle after an accept");

   // a replaced entry is always a new address
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_already_seen && rsp_replaced_entry))
      else $error("seen and replaced both set");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_already_seen) && $stable(rsp_replaced_entry)))
      else $error("stalled response changed");

endmodule

bind hashed_seen_filter hsf_checker u_hsf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_already_seen   (rsp_ch.already_seen),
   .rsp_replaced_entry (rsp_ch.replaced_entry)
);
